/* hw/rtl/compacting_array_list_defines.svh */
// Assertion macros for the compacting array list.
// Used by the datapath; expects clock and reset in the including scope.
`ifndef COMPACTING_ARRAY_LIST_DEFINES_SVH
`define COMPACTING_ARRAY_LIST_DEFINES_SVH

// checked outside reset
`define CAL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// checked through reset as well
`define CAL_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

/* hw/rtl/cal_pkg.sv */
// Shared types and constants for the compacting array list.
// No dependencies; used by cal_ctrl, cal_dp and compacting_array_list.
package cal_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 8;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_READ,
      ST_READ_WAIT,
      ST_SCAN_FIND,
      ST_SCAN_DEL,
      ST_FOUND,
      ST_MISS,
      ST_SHIFT
   } state_type;

   typedef enum logic [2:0] {
      RES_MISS,
      RES_APPEND,
      RES_READ,
      RES_HIT,
      RES_REMOVE
   } res_type;

   typedef struct packed {
      logic    load;
      logic    issue;
      logic    rd_pos;
      logic    take_hit;
      logic    shift_wr;
      logic    commit;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic ptr_lt_cnt;
      logic in_flight;
      logic hit;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/cal_ctrl.sv */
// Controller state machine for the compacting array list.
// Depends on cal_pkg; drives datapath commands from its status.
module cal_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_mode,
   output logic              req_stall,
   input  cal_pkg::sts_type  sts,
   output cal_pkg::cmd_type  cmd
);

   cal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cal_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (cal_pkg::mode_type'(req_mode))
                  cal_pkg::MODE_APPEND: state_in = cal_pkg::ST_APPEND;
                  cal_pkg::MODE_SEARCH: state_in = cal_pkg::ST_SCAN_FIND;
                  cal_pkg::MODE_REMOVE: state_in = cal_pkg::ST_SCAN_DEL;
                  default:              state_in = cal_pkg::ST_READ;
               endcase
            end
         end
         cal_pkg::ST_READ: state_in = cal_pkg::ST_READ_WAIT;
         cal_pkg::ST_SCAN_FIND, cal_pkg::ST_SCAN_DEL: begin
            if (sts.hit) begin
               state_in = (state_ff == cal_pkg::ST_SCAN_DEL) ? cal_pkg::ST_SHIFT
                                                             : cal_pkg::ST_FOUND;
            end else if (!sts.ptr_lt_cnt && !sts.in_flight) begin
               state_in = cal_pkg::ST_MISS;
            end
         end
         cal_pkg::ST_SHIFT: begin
            if (!sts.ptr_lt_cnt && !sts.in_flight && sts.out_free) begin
               state_in = cal_pkg::ST_IDLE;
            end
         end
         cal_pkg::ST_APPEND, cal_pkg::ST_READ_WAIT, cal_pkg::ST_FOUND,
         cal_pkg::ST_MISS: begin
            if (sts.out_free) begin
               state_in = cal_pkg::ST_IDLE;
            end
         end
         default: state_in = cal_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.res   = cal_pkg::RES_MISS;
      req_stall = 1'b1;
      case (state_ff)
         cal_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         cal_pkg::ST_APPEND: begin
            cmd.commit = sts.out_free;
            cmd.res    = cal_pkg::RES_APPEND;
         end
         cal_pkg::ST_READ: cmd.rd_pos = 1'b1;
         cal_pkg::ST_READ_WAIT: begin
            cmd.commit = sts.out_free;
            cmd.res    = cal_pkg::RES_READ;
         end
         cal_pkg::ST_SCAN_FIND, cal_pkg::ST_SCAN_DEL: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
            end else begin
               cmd.issue = sts.ptr_lt_cnt;
            end
         end
         cal_pkg::ST_FOUND: begin
            cmd.commit = sts.out_free;
            cmd.res    = cal_pkg::RES_HIT;
         end
         cal_pkg::ST_MISS: begin
            cmd.commit = sts.out_free;
            cmd.res    = cal_pkg::RES_MISS;
         end
         cal_pkg::ST_SHIFT: begin
            cmd.shift_wr = 1'b1;
            cmd.issue    = sts.ptr_lt_cnt;
            cmd.res      = cal_pkg::RES_REMOVE;
            cmd.commit   = !sts.ptr_lt_cnt && !sts.in_flight && sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* hw/rtl/cal_dp.sv */
// Datapath for the compacting array list: entry memory, count, scan pointer
// and result register. Depends on cal_pkg and compacting_array_list_defines.svh.
`include "compacting_array_list_defines.svh"

module cal_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  cal_pkg::cmd_type       cmd,
   output cal_pkg::sts_type       sts,
   input  logic [7:0]             req_key,
   input  logic [6:0]             req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_ok,
   output logic [6:0]             rsp_index,
   output logic [7:0]             rsp_value,
   output logic [7:0]             rsp_count
);

   localparam cal_pkg::cnt_type CAP = cal_pkg::cnt_type'(cal_pkg::CAPACITY);

   cal_pkg::key_type mem [cal_pkg::CAPACITY];

   cal_pkg::key_type key_ff;
   cal_pkg::idx_type pos_ff;
   cal_pkg::cnt_type cnt_ff, cnt_in;
   cal_pkg::cnt_type ptr_ff, ptr_in;
   cal_pkg::idx_type hit_ff;
   cal_pkg::key_type rd_data_ff;
   cal_pkg::idx_type rd_addr_ff;
   logic             rd_vld_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             ok_ff, ok_in;
   cal_pkg::idx_type index_ff, index_in;
   cal_pkg::key_type value_ff, value_in;
   cal_pkg::cnt_type count_ff;

   cal_pkg::idx_type rd_addr;
   logic             rd_en;
   logic             we;
   cal_pkg::idx_type wa;
   cal_pkg::key_type wd;
   logic             out_free;
   logic             app_wr;
   logic             shift_we;
   cal_pkg::cnt_type cnt_inc;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.ptr_lt_cnt = ptr_ff < cnt_ff;
   assign sts.in_flight  = rd_vld_ff;
   assign sts.hit        = rd_vld_ff && (rd_data_ff == key_ff);
   assign sts.out_free   = out_free;

   assign app_wr   = cmd.commit && cmd.res == cal_pkg::RES_APPEND && cnt_ff < CAP;
   assign shift_we = cmd.shift_wr && rd_vld_ff;
   assign cnt_inc  = cnt_ff + cal_pkg::cnt_type'(1);

   // memory ports
   assign rd_en   = cmd.issue || cmd.rd_pos;
   assign rd_addr = cmd.rd_pos ? pos_ff : ptr_ff[cal_pkg::IDX_W-1:0];

   always_comb begin
      we = 1'b0;
      wa = cnt_ff[cal_pkg::IDX_W-1:0];
      wd = key_ff;
      if (app_wr) begin
         we = 1'b1;
      end else if (shift_we) begin
         we = 1'b1;
         wa = rd_addr_ff - cal_pkg::idx_type'(1);
         wd = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result
   always_comb begin
      ok_in    = 1'b0;
      index_in = '0;
      value_in = '0;
      cnt_in   = cnt_ff;
      case (cmd.res)
         cal_pkg::RES_APPEND: begin
            if (cnt_ff < CAP) begin
               ok_in    = 1'b1;
               index_in = cnt_ff[cal_pkg::IDX_W-1:0];
               if (cmd.commit) begin
                  cnt_in = cnt_inc;
               end
            end
         end
         cal_pkg::RES_READ: begin
            if (cal_pkg::cnt_type'(pos_ff) < cnt_ff) begin
               ok_in    = 1'b1;
               index_in = pos_ff;
               value_in = rd_data_ff;
            end
         end
         cal_pkg::RES_HIT: begin
            ok_in    = 1'b1;
            index_in = hit_ff;
         end
         cal_pkg::RES_REMOVE: begin
            ok_in    = 1'b1;
            index_in = hit_ff;
            if (cmd.commit) begin
               cnt_in = cnt_ff - cal_pkg::cnt_type'(1);
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.take_hit) begin
         ptr_in = cal_pkg::cnt_type'(rd_addr_ff) + cal_pkg::cnt_type'(1);
      end else if (cmd.issue) begin
         ptr_in = ptr_ff + cal_pkg::cnt_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_key;
         pos_ff <= req_position;
      end
      if (cmd.issue) begin
         rd_addr_ff <= ptr_ff[cal_pkg::IDX_W-1:0];
      end
      if (cmd.take_hit) begin
         hit_ff <= rd_addr_ff;
      end
      if (cmd.commit) begin
         ok_ff    <= ok_in;
         index_ff <= index_in;
         value_ff <= value_in;
         count_ff <= cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = ok_ff;
   assign rsp_index = index_ff;
   assign rsp_value = value_ff;
   assign rsp_count = count_ff;

   `CAL_ASSERT(a_cnt_range, cnt_ff <= CAP, "entry count beyond capacity")
   `CAL_ASSERT(a_append_grows, app_wr |=> (cnt_ff == $past(cnt_inc)), "append did not grow")
   `CAL_ASSERT(a_shift_addr, shift_we |-> (rd_addr_ff != '0), "shift write below index zero")
   `CAL_ASSERT(a_commit_free, cmd.commit |-> out_free, "result overwrote a waiting word")
   `CAL_ASSERT_RST(a_reset_clear, reset |=> ((cnt_ff == '0) && !rsp_valid_ff), "reset incomplete")

endmodule

/* hw/rtl/compacting_array_list.sv */
// Compacting array list top level: append, search, remove and read-at on a list of bytes.
// Search and remove scan the entries from index 0 and stop at the first hit; a remove hit
// then shifts every later entry down by one index. The result is registered at the commit.
// One word at a time: the next is taken in the cycle after the result is registered; a
// stalled result holds the commit and with it the input.
// Reset clears the state, the count and the result valid; entries are not cleared.
module compacting_array_list (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_key,
   input  logic [6:0] req_position,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_ok,
   output logic [6:0] rsp_index,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_count
);

   cal_pkg::cmd_type cmd;
   cal_pkg::sts_type sts;

   cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cal_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_key      (req_key),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ok       (rsp_ok),
      .rsp_index    (rsp_index),
      .rsp_value    (rsp_value),
      .rsp_count    (rsp_count)
   );

endmodule
